@@ hw/rtl/cst_pkg.sv @@
// Shared constants, codes and types of the sparse CSR to CSC transpose block.
`default_nettype none

package cst_pkg;

    // Capacities.
    localparam int MAX_NONZEROS = 4096;
    localparam int MAX_COLUMNS  = 1024;
    localparam int MAX_ROWS     = 1024;

    // Field and address widths.
    localparam int NZ_AW     = $clog2(MAX_NONZEROS);
    localparam int CNT_W     = NZ_AW + 1;
    localparam int COL_W     = $clog2(MAX_COLUMNS);
    localparam int PTR_AW    = COL_W + 1;
    localparam int PTR_DEPTH = MAX_COLUMNS + 1;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 11;
    localparam int POS_W     = 13;
    localparam int REQ_W     = 3;
    localparam int STAT_W    = 3;
    localparam int LOAD_W    = ROW_W + COL_W + VAL_W;
    localparam int RES_W     = ROW_W + VAL_W;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_START        = 3'd0,
        REQ_LOAD         = 3'd1,
        REQ_TRANSPOSE    = 3'd2,
        REQ_READ_ENTRY   = 3'd3,
        REQ_READ_POINTER = 3'd4
    } req_t;

    // Status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_COLUMN = 3'd2,
        ST_RANGE  = 3'd3,
        ST_NOT_T  = 3'd4
    } status_t;

    // Sequencer states, one-hot.
    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_RD_ENTRY = 12'b0000_0000_0010,
        S_RD_PTR   = 12'b0000_0000_0100,
        T_CLR      = 12'b0000_0000_1000,
        T_CNT_RD   = 12'b0000_0001_0000,
        T_CNT_CHK  = 12'b0000_0010_0000,
        T_CNT_WR   = 12'b0000_0100_0000,
        T_PRE_RD   = 12'b0000_1000_0000,
        T_PRE_WR   = 12'b0001_0000_0000,
        T_SCT_RD   = 12'b0010_0000_0000,
        T_SCT_CHK  = 12'b0100_0000_0000,
        T_SCT_WR   = 12'b1000_0000_0000
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/cst_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, and read through a registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sparse_csr_to_csc_transpose_top.sv @@
// Top level of the sparse CSR to CSC transpose block: request sequencer and its memories.
//
//   Channel   Direction  Handshake              Contents
//   s_        in         s_valid / s_ready      request word: type, row, column, value, position
//   m_        out        m_valid / m_ready      status word: status, row, value, pointer
//   cfg_      in         cfg_valid / cfg_ready  source column count (11 bits)
//
// Start, load, unknown and rejected requests load the result register at the accepting
// edge, so their word is valid in the next cycle.
// Entry and pointer reads load their word from the S_RD_ENTRY or S_RD_PTR state, after the registered read.
// A transpose loads its word once its clear, count, prefix-sum and scatter passes are done;
// an entry whose column is out of range is skipped by the count and scatter passes.
// Reset is synchronous and needs no clearing pass; no request is taken while the
// result register is full and not being taken, or while a transpose is running.
`default_nettype none

module sparse_csr_to_csc_transpose_top
    import cst_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [REQ_W-1:0]  s_req_type,
    input  wire logic [ROW_W-1:0]  s_row_index,
    input  wire logic [COL_W-1:0]  s_column_index,
    input  wire logic [VAL_W-1:0]  s_value_bits,
    input  wire logic [POS_W-1:0]  s_read_position,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [STAT_W-1:0]      m_status,
    output logic [ROW_W-1:0]       m_out_row,
    output logic [VAL_W-1:0]       m_out_value,
    output logic [CNT_W-1:0]       m_out_pointer,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    state_t               state_reg, state_next;
    logic [PTR_AW-1:0]    nc_reg, nc_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 flag_reg, flag_next;
    logic [CNT_W-1:0]     placed_reg, placed_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [PTR_AW-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]     acc_reg, acc_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [VAL_W-1:0]     val_reg, val_next;

    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [ROW_W-1:0]     m_row_reg, m_row_next;
    logic [VAL_W-1:0]     m_value_reg, m_value_next;
    logic [CNT_W-1:0]     m_ptr_reg, m_ptr_next;

    logic                 in_acc, cfg_acc, out_load;
    logic [CNT_W-1:0]     sum;

    // Memory ports.
    logic                 ld_we;
    logic [LOAD_W-1:0]    ld_rd;
    logic [ROW_W-1:0]     ld_row;
    logic [COL_W-1:0]     ld_col;
    logic [VAL_W-1:0]     ld_val;
    logic                 ptr_we;
    logic [PTR_AW-1:0]    ptr_waddr, ptr_raddr;
    logic [CNT_W-1:0]     ptr_wdata, ptr_rd;
    logic                 fc_we;
    logic [PTR_AW-1:0]    fc_waddr, fc_raddr;
    logic [CNT_W-1:0]     fc_wdata, fc_rd;
    logic                 res_we;
    logic [RES_W-1:0]     res_rd;

    assign ld_row = ld_rd[LOAD_W-1 -: ROW_W];
    assign ld_col = ld_rd[VAL_W +: COL_W];
    assign ld_val = ld_rd[VAL_W-1:0];

    // Handshakes; configuration wins over a request in the same cycle.
    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_ready   = (state_reg == S_IDLE) && (!m_valid_reg || m_ready) && !cfg_valid;
    assign in_acc    = s_valid && s_ready;

    assign sum = acc_reg + ptr_rd;

    // Loaded entries, in load order.
    cst_ram #(.WIDTH(LOAD_W), .DEPTH(MAX_NONZEROS)) u_load_mem (
        .aclk    (aclk),
        .we      (ld_we),
        .waddr   (count_reg[NZ_AW-1:0]),
        .wdata   ({s_row_index, s_column_index, s_value_bits}),
        .raddr   (idx_reg[NZ_AW-1:0]),
        .rd_data (ld_rd)
    );

    // Column counts, then column pointers.
    cst_ram #(.WIDTH(CNT_W), .DEPTH(PTR_DEPTH)) u_ptr_mem (
        .aclk    (aclk),
        .we      (ptr_we),
        .waddr   (ptr_waddr),
        .wdata   (ptr_wdata),
        .raddr   (ptr_raddr),
        .rd_data (ptr_rd)
    );

    // Fill cursors used during the scatter.
    cst_ram #(.WIDTH(CNT_W), .DEPTH(PTR_DEPTH)) u_fc_mem (
        .aclk    (aclk),
        .we      (fc_we),
        .waddr   (fc_waddr),
        .wdata   (fc_wdata),
        .raddr   (fc_raddr),
        .rd_data (fc_rd)
    );

    // Transposed entries.
    cst_ram #(.WIDTH(RES_W), .DEPTH(MAX_NONZEROS)) u_res_mem (
        .aclk    (aclk),
        .we      (res_we),
        .waddr   (fc_rd[NZ_AW-1:0]),
        .wdata   ({row_reg, val_reg}),
        .raddr   (s_read_position[NZ_AW-1:0]),
        .rd_data (res_rd)
    );

    // Memory port steering by state.
    always_comb begin
        ld_we     = 1'b0;
        ptr_we    = 1'b0;
        ptr_waddr = k_reg;
        ptr_wdata = '0;
        ptr_raddr = s_read_position[PTR_AW-1:0];
        fc_we     = 1'b0;
        fc_waddr  = k_reg;
        fc_wdata  = '0;
        fc_raddr  = PTR_AW'(ld_col);
        res_we    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                ld_we = in_acc && (req_t'(s_req_type) == REQ_LOAD)
                        && (count_reg < CNT_W'(MAX_NONZEROS))
                        && (PTR_AW'(s_column_index) < nc_reg)
                        && ({1'b0, s_row_index} < (ROW_W + 1)'(MAX_ROWS));
            end
            T_CLR: begin
                ptr_we = 1'b1;
                fc_we  = 1'b1;
            end
            T_CNT_CHK: begin
                ptr_raddr = PTR_AW'(ld_col) + PTR_AW'(1);
            end
            T_CNT_WR: begin
                ptr_we    = 1'b1;
                ptr_waddr = PTR_AW'(col_reg) + PTR_AW'(1);
                ptr_wdata = ptr_rd + CNT_W'(1);
            end
            T_PRE_RD: begin
                ptr_raddr = k_reg;
            end
            T_PRE_WR: begin
                ptr_we    = 1'b1;
                ptr_wdata = sum;
                fc_we     = 1'b1;
                fc_wdata  = sum;
            end
            T_SCT_WR: begin
                res_we   = 1'b1;
                fc_we    = 1'b1;
                fc_waddr = PTR_AW'(col_reg);
                fc_wdata = fc_rd + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Request handling and transpose sequencer.
    always_comb begin
        state_next    = state_reg;
        nc_next       = nc_reg;
        count_next    = count_reg;
        flag_next     = flag_reg;
        placed_next   = placed_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        val_next      = val_reg;
        out_load      = 1'b0;
        m_status_next = ST_OK;
        m_row_next    = '0;
        m_value_next  = '0;
        m_ptr_next    = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (cfg_acc) begin
                    nc_next   = (cfg_data > CFG_W'(MAX_COLUMNS)) ? PTR_AW'(MAX_COLUMNS)
                                                                  : PTR_AW'(cfg_data);
                    flag_next = 1'b0;
                end
                if (in_acc) begin
                    case (req_t'(s_req_type))
                        REQ_START: begin
                            out_load   = 1'b1;
                            count_next = '0;
                            flag_next  = 1'b0;
                        end
                        REQ_LOAD: begin
                            out_load = 1'b1;
                            if (count_reg >= CNT_W'(MAX_NONZEROS)) begin
                                m_status_next = ST_FULL;
                                m_ptr_next    = count_reg;
                            end else if (PTR_AW'(s_column_index) >= nc_reg) begin
                                m_status_next = ST_COLUMN;
                                m_ptr_next    = count_reg;
                            end else if ({1'b0, s_row_index} >= (ROW_W + 1)'(MAX_ROWS)) begin
                                m_status_next = ST_RANGE;
                                m_ptr_next    = count_reg;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                                flag_next  = 1'b0;
                                m_ptr_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_TRANSPOSE: begin
                            state_next = T_CLR;
                            k_next     = '0;
                        end
                        REQ_READ_ENTRY: begin
                            if (!flag_reg) begin
                                out_load      = 1'b1;
                                m_status_next = ST_NOT_T;
                            end else if ((s_read_position >= placed_reg)
                                         || (s_read_position >= POS_W'(MAX_NONZEROS))) begin
                                out_load      = 1'b1;
                                m_status_next = ST_RANGE;
                            end else begin
                                state_next = S_RD_ENTRY;
                            end
                        end
                        REQ_READ_POINTER: begin
                            if (!flag_reg) begin
                                out_load      = 1'b1;
                                m_status_next = ST_NOT_T;
                            end else if (s_read_position > POS_W'(nc_reg)) begin
                                out_load      = 1'b1;
                                m_status_next = ST_RANGE;
                            end else begin
                                state_next = S_RD_PTR;
                            end
                        end
                        default: begin
                            out_load      = 1'b1;
                            m_status_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_RD_ENTRY: begin
                out_load     = 1'b1;
                m_row_next   = res_rd[RES_W-1 -: ROW_W];
                m_value_next = res_rd[VAL_W-1:0];
                state_next   = S_IDLE;
            end
            S_RD_PTR: begin
                out_load   = 1'b1;
                m_ptr_next = ptr_rd;
                state_next = S_IDLE;
            end
            T_CLR: begin
                if (k_reg == nc_reg) begin
                    state_next = T_CNT_RD;
                    idx_next   = '0;
                end else begin
                    k_next = k_reg + PTR_AW'(1);
                end
            end
            T_CNT_RD: begin
                if (idx_reg == count_reg) begin
                    state_next = T_PRE_RD;
                    k_next     = PTR_AW'(1);
                    acc_next   = '0;
                end else begin
                    state_next = T_CNT_CHK;
                end
            end
            T_CNT_CHK: begin
                if (PTR_AW'(ld_col) < nc_reg) begin
                    col_next   = ld_col;
                    state_next = T_CNT_WR;
                end else begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = T_CNT_RD;
                end
            end
            T_CNT_WR: begin
                idx_next   = idx_reg + CNT_W'(1);
                state_next = T_CNT_RD;
            end
            T_PRE_RD: begin
                if (k_reg > nc_reg) begin
                    state_next = T_SCT_RD;
                    idx_next   = '0;
                end else begin
                    state_next = T_PRE_WR;
                end
            end
            T_PRE_WR: begin
                acc_next   = sum;
                k_next     = k_reg + PTR_AW'(1);
                state_next = T_PRE_RD;
            end
            T_SCT_RD: begin
                if (idx_reg == count_reg) begin
                    out_load    = 1'b1;
                    m_ptr_next  = acc_reg;
                    placed_next = acc_reg;
                    flag_next   = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    state_next = T_SCT_CHK;
                end
            end
            T_SCT_CHK: begin
                if (PTR_AW'(ld_col) < nc_reg) begin
                    col_next   = ld_col;
                    row_next   = ld_row;
                    val_next   = ld_val;
                    state_next = T_SCT_WR;
                end else begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = T_SCT_RD;
                end
            end
            T_SCT_WR: begin
                idx_next   = idx_reg + CNT_W'(1);
                state_next = T_SCT_RD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result register empties when taken and fills when a word is ready.
    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            nc_reg      <= PTR_AW'(MAX_COLUMNS);
            count_reg   <= '0;
            flag_reg    <= 1'b0;
            placed_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            nc_reg      <= nc_next;
            count_reg   <= count_next;
            flag_reg    <= flag_next;
            placed_reg  <= placed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        k_reg   <= k_next;
        acc_reg <= acc_next;
        col_reg <= col_next;
        row_reg <= row_next;
        val_reg <= val_next;
        if (out_load) begin
            m_status_reg <= m_status_next;
            m_row_reg    <= m_row_next;
            m_value_reg  <= m_value_next;
            m_ptr_reg    <= m_ptr_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_row     = m_row_reg;
    assign m_out_value   = m_value_reg;
    assign m_out_pointer = m_ptr_reg;

    // A finished transpose never claims more entries than are stored.
    a_placed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        flag_reg |-> (placed_reg <= count_reg))
        else $error("placed count exceeds stored entries");

    // The entry store never overfills.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_NONZEROS))
        else $error("entry count beyond capacity");

    // Pointer writes stay at or below the active column count.
    a_ptr_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_we |-> (ptr_waddr <= nc_reg))
        else $error("column pointer write out of range");

    // Scatter slots fall below the total placed.
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_we |-> (fc_rd < acc_reg))
        else $error("scatter slot beyond placed count");

    // A result is only produced into a free or draining output register.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten");

endmodule

`default_nettype wire
